// ===== src/sitd_pkg.sv =====
// Shared types and constants for the signed integer to decimal text converter.
package sitd_pkg;

  localparam int MAG_W       = 32;
  localparam int CHAR_W      = 6;
  localparam int DIG_W       = 4;
  localparam int MAX_DIGITS  = 10;
  localparam int CNT_W       = 4;
  localparam int QUO_W       = 29;
  localparam int PROD_W      = 2 * MAG_W;
  localparam int RECIP_SHIFT = 35;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [MAG_W-1:0]  RECIP10    = 32'hCCCC_CCCD;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } item_t;

endpackage

// ===== src/signed_int_to_decimal_ascii.sv =====
// Converts a 32-bit two's-complement integer to its decimal ASCII text, one
// character per output beat, minus sign first for negative values, no leading
// zeros, last_char set on the final character. The front end takes an input
// beat whenever its two-entry queue has room. The back end converts one item
// at a time: it picks the item up, then for each decimal digit does a
// reciprocal multiply and then a remainder step, then emits the characters
// one per beat while the output is not stalled.
module signed_int_to_decimal_ascii import sitd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [MAG_W-1:0]  in_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_char_code,
  output logic              out_last_char
);

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  sitd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_value (in_value),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  sitd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

endmodule

// ===== src/sitd_front.sv =====
// Front end: accept input beats, split sign and magnitude, queue them for the back end.
module sitd_front import sitd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [MAG_W-1:0]  in_value,
  output logic              q_valid,
  output item_t             q_item,
  input  logic              q_pop
);

  item_t       buf_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push;
  item_t       cls;

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = buf_r[rd_ptr_r];

  always_comb begin
    cls.neg = in_value[MAG_W-1];
    cls.mag = in_value[MAG_W-1] ? (~in_value + MAG_W'(1)) : in_value;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      buf_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== src/sitd_back.sv =====
// Back end: peel decimal digits by reciprocal multiply, then emit characters one beat at a time.
module sitd_back import sitd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_char_code,
  output logic              out_last_char
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_EMIT} state_t;

  state_t              state_r, state_nxt;
  logic [MAG_W-1:0]    mag_r, mag_nxt;
  logic                neg_r, neg_nxt;
  logic                sign_pend_r, sign_pend_nxt;
  logic [CNT_W-1:0]    ndig_r, ndig_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [DIG_W-1:0]    dig_r [MAX_DIGITS];
  logic                dig_we;
  logic [DIG_W-1:0]    dig_wdata;
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;
  logic [QUO_W-1:0]    quo;
  logic [MAG_W-1:0]    ten_q;
  logic [MAG_W-1:0]    rem;
  logic                free;

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last_char = out_last_r;

  assign quo   = prod_r[PROD_W-1:RECIP_SHIFT];
  assign ten_q = {quo, 3'b000} + {2'b00, quo, 1'b0};
  assign rem   = mag_r - ten_q;
  assign free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    sign_pend_nxt = sign_pend_r;
    ndig_nxt      = ndig_r;
    prod_nxt      = prod_r;
    dig_we        = 1'b0;
    dig_wdata     = rem[DIG_W-1:0];
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          mag_nxt   = q_item.mag;
          neg_nxt   = q_item.neg;
          ndig_nxt  = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = {{MAG_W{1'b0}}, mag_r} * {{MAG_W{1'b0}}, RECIP10};
        state_nxt = S_DIV;
      end
      S_DIV: begin
        dig_we   = 1'b1;
        ndig_nxt = ndig_r + CNT_W'(1);
        mag_nxt  = {{(MAG_W-QUO_W){1'b0}}, quo};
        if (quo == '0 || ndig_r == CNT_W'(MAX_DIGITS - 1)) begin
          sign_pend_nxt = neg_r;
          state_nxt     = S_EMIT;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_EMIT: begin
        if (free) begin
          out_valid_nxt = 1'b1;
          if (sign_pend_r) begin
            out_char_nxt  = CHAR_MINUS;
            out_last_nxt  = 1'b0;
            sign_pend_nxt = 1'b0;
          end else begin
            out_char_nxt = CHAR_ZERO + {{(CHAR_W-DIG_W){1'b0}}, dig_r[ndig_r - CNT_W'(1)]};
            out_last_nxt = (ndig_r == CNT_W'(1));
            ndig_nxt     = ndig_r - CNT_W'(1);
            if (ndig_r == CNT_W'(1)) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sign_pend_r <= 1'b0;
      ndig_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sign_pend_r <= sign_pend_nxt;
      ndig_r      <= ndig_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    prod_r     <= prod_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (dig_we) begin
      dig_r[ndig_r] <= dig_wdata;
    end
  end

endmodule

// ===== src/sitd_checker.sv =====
// Port-level checks for the decimal text converter, bound to the top level.
module sitd_checker import sitd_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [MAG_W-1:0]  in_value,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CHAR_W-1:0] out_char_code,
  input logic              out_last_char
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char_code) && $stable(out_last_char))
    else $error("stalled output beat changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_value))
    else $error("stalled input beat changed");

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_char_code == CHAR_MINUS ||
                  (out_char_code >= CHAR_ZERO && out_char_code <= CHAR_ZERO + 6'd9))
    else $error("output character is not a digit or minus sign");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_code == CHAR_MINUS |-> !out_last_char)
    else $error("minus sign flagged as last character");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind signed_int_to_decimal_ascii sitd_checker u_sitd_checker (.*);
